// ===== rtl/lru_keyed_entry_cache_macros.svh =====
// Assertion macros for the LRU keyed entry cache.
`ifndef LRU_KEYED_ENTRY_CACHE_MACROS_SVH
`define LRU_KEYED_ENTRY_CACHE_MACROS_SVH
`ifndef SYNTH
`define LKC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LKC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LKC_ASSERT(lbl, prop, msg)
`define LKC_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/lkc_pkg.sv =====
`default_nettype none

package lkc_pkg;

  localparam int unsigned KEY_W      = 22;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned OCC_W      = 7;
  localparam int unsigned IDX_MAX_W  = 8;
  localparam int unsigned RANK_MAX_W = 8;
  localparam int unsigned KEY_MAX_W  = 32;

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_PROMOTE,
    UPD_INSERT,
    UPD_REMOVE,
    UPD_CLEAR
  } upd_op_e;

  typedef struct packed {
    upd_op_e                 op;
    logic [IDX_MAX_W-1:0]    idx;
    logic [RANK_MAX_W-1:0]   rank;
  } upd_t;

  typedef struct packed {
    logic                    hit;
    logic [IDX_MAX_W-1:0]    hit_idx;
    logic [RANK_MAX_W-1:0]   hit_rank;
    logic                    free;
    logic [IDX_MAX_W-1:0]    free_idx;
    logic                    lru;
    logic [IDX_MAX_W-1:0]    lru_idx;
    logic [KEY_MAX_W-1:0]    lru_key;
  } scan_t;

  typedef struct packed {
    logic                    hit;
    logic                    inserted;
    logic                    evicted;
    logic [KEY_W-1:0]        evicted_key;
    logic [SLOT_W-1:0]       slot;
    logic [OCC_W-1:0]        occupancy;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/lkc_cell.sv =====
`default_nettype none

module lkc_cell #(
  parameter int unsigned Index    = 0,
  parameter int unsigned Capacity = 64,
  parameter int unsigned KeyBits  = 22
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [KeyBits-1:0] key_i,
  input  wire lkc_pkg::upd_t      upd_i,
  input  wire lkc_pkg::scan_t     scan_i,
  output lkc_pkg::scan_t          scan_o
);

  localparam int unsigned RankW   = $clog2(Capacity);
  localparam int unsigned IdxMaxW = lkc_pkg::IDX_MAX_W;
  localparam int unsigned RnkMaxW = lkc_pkg::RANK_MAX_W;
  localparam int unsigned KeyMaxW = lkc_pkg::KEY_MAX_W;
  localparam logic [IdxMaxW-1:0] MyIdx   = IdxMaxW'(Index);
  localparam logic [RankW-1:0]   LruRank = RankW'(Capacity - 1);

  logic [KeyBits-1:0] key_q, key_d;
  logic               valid_q, valid_d;
  logic [RankW-1:0]   rank_q, rank_d;
  lkc_pkg::scan_t     scan_q, scan_d;
  logic               sel;
  logic               match;
  logic [RankW-1:0]   ref_rank;

  assign sel      = (upd_i.idx == MyIdx);
  assign match    = valid_q && (key_q == key_i);
  assign ref_rank = upd_i.rank[RankW-1:0];

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    rank_d  = rank_q;
    unique case (upd_i.op)
      lkc_pkg::UPD_PROMOTE: begin
        if (sel) begin
          rank_d = '0;
        end else if (valid_q && rank_q < ref_rank) begin
          rank_d = rank_q + RankW'(1);
        end
      end
      lkc_pkg::UPD_INSERT: begin
        if (sel) begin
          key_d   = key_i;
          valid_d = 1'b1;
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + RankW'(1);
        end
      end
      lkc_pkg::UPD_REMOVE: begin
        if (sel) begin
          valid_d = 1'b0;
          rank_d  = '0;
        end else if (valid_q && rank_q > ref_rank) begin
          rank_d = rank_q - RankW'(1);
        end
      end
      lkc_pkg::UPD_CLEAR: begin
        valid_d = 1'b0;
        rank_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    scan_d = scan_i;
    if (!scan_i.hit && match) begin
      scan_d.hit      = 1'b1;
      scan_d.hit_idx  = MyIdx;
      scan_d.hit_rank = RnkMaxW'(rank_q);
    end
    if (!scan_i.free && !valid_q) begin
      scan_d.free     = 1'b1;
      scan_d.free_idx = MyIdx;
    end
    if (valid_q && rank_q == LruRank) begin
      scan_d.lru     = 1'b1;
      scan_d.lru_idx = MyIdx;
      scan_d.lru_key = KeyMaxW'(key_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      scan_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      scan_q  <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign scan_o = scan_q;

endmodule

`default_nettype wire

// ===== rtl/lkc_ctrl.sv =====
`default_nettype none
`include "lru_keyed_entry_cache_macros.svh"

module lkc_ctrl #(
  parameter int unsigned Capacity = 64,
  parameter int unsigned KeyBits  = 22
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [1:0]                command_i,
  input  wire logic [lkc_pkg::KEY_W-1:0] key_i,
  input  wire logic                      fill_ok_i,
  input  wire lkc_pkg::scan_t            scan_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [KeyBits-1:0]             key_o,
  output lkc_pkg::upd_t                  upd_o,
  output lkc_pkg::res_t                  res_o
);

  localparam int unsigned CntW   = $clog2(Capacity + 1);
  localparam int unsigned StepW  = $clog2(Capacity);
  localparam int unsigned KeyW   = lkc_pkg::KEY_W;
  localparam int unsigned SlotW  = lkc_pkg::SLOT_W;
  localparam int unsigned OccW   = lkc_pkg::OCC_W;
  localparam logic [CntW-1:0] Full = CntW'(Capacity);

  lkc_pkg::state_e    state_q, state_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [1:0]         cmd_q, cmd_d;
  logic [KeyBits-1:0] key_q, key_d;
  logic               fill_q, fill_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               done_q, done_d;
  lkc_pkg::res_t      res_q, res_d;
  lkc_pkg::upd_t      upd;
  logic               accept;
  logic               full;

  assign accept = start_i && (state_q == lkc_pkg::ST_IDLE);
  assign full   = (count_q == Full);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_d   = cmd_q;
    key_d   = key_q;
    fill_d  = fill_q;
    count_d = count_q;
    done_d  = 1'b0;
    res_d   = res_q;
    upd     = '0;
    upd.op  = lkc_pkg::UPD_NONE;
    unique case (state_q)
      lkc_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d   = command_i;
          key_d   = KeyBits'(key_i);
          fill_d  = fill_ok_i;
          step_d  = StepW'(Capacity - 1);
          state_d = lkc_pkg::ST_SCAN;
        end
      end
      lkc_pkg::ST_SCAN: begin
        if (step_q == '0) begin
          state_d = lkc_pkg::ST_UPDATE;
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      lkc_pkg::ST_UPDATE: begin
        res_d = '0;
        unique case (cmd_q)
          lkc_pkg::CMD_GET: begin
            if (scan_i.hit) begin
              upd.op       = lkc_pkg::UPD_PROMOTE;
              upd.idx      = scan_i.hit_idx;
              upd.rank     = scan_i.hit_rank;
              res_d.hit    = 1'b1;
              res_d.slot   = scan_i.hit_idx[SlotW-1:0];
            end else if (fill_q && full && scan_i.lru) begin
              upd.op            = lkc_pkg::UPD_INSERT;
              upd.idx           = scan_i.lru_idx;
              res_d.inserted    = 1'b1;
              res_d.evicted     = 1'b1;
              res_d.evicted_key = scan_i.lru_key[KeyW-1:0];
              res_d.slot        = scan_i.lru_idx[SlotW-1:0];
            end else if (fill_q && !full && scan_i.free) begin
              upd.op         = lkc_pkg::UPD_INSERT;
              upd.idx        = scan_i.free_idx;
              res_d.inserted = 1'b1;
              res_d.slot     = scan_i.free_idx[SlotW-1:0];
              count_d        = count_q + CntW'(1);
            end
          end
          lkc_pkg::CMD_REMOVE: begin
            if (scan_i.hit) begin
              upd.op    = lkc_pkg::UPD_REMOVE;
              upd.idx   = scan_i.hit_idx;
              upd.rank  = scan_i.hit_rank;
              res_d.hit = 1'b1;
              if (count_q != '0) begin
                count_d = count_q - CntW'(1);
              end
            end
          end
          lkc_pkg::CMD_CLEAR: begin
            upd.op  = lkc_pkg::UPD_CLEAR;
            count_d = '0;
          end
          default: begin
          end
        endcase
        res_d.occupancy = OccW'(count_d);
        done_d          = 1'b1;
        state_d         = lkc_pkg::ST_IDLE;
      end
      default: begin
        state_d = lkc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkc_pkg::ST_IDLE;
      step_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    fill_q <= fill_d;
    res_q  <= res_d;
  end

  assign busy_o = (state_q != lkc_pkg::ST_IDLE);
  assign done_o = done_q;
  assign key_o  = key_q;
  assign upd_o  = upd;
  assign res_o  = res_q;

  `LKC_ASSERT_IMP(a_done_upd, done_q, $past(state_q == lkc_pkg::ST_UPDATE), "stray strobe")
  `LKC_ASSERT(a_busy_after_accept, (start_i && !busy_o) |=> busy_o, "accept without busy")
  `LKC_ASSERT(a_count_bound, count_q <= Full, "entry count above capacity")
  `LKC_ASSERT_IMP(a_evict_full, done_q && res_q.evicted, res_q.inserted && full, "bad evict")
  `LKC_ASSERT_IMP(a_hit_not_insert, done_q, !(res_q.hit && res_q.inserted), "hit inserted")

endmodule

`default_nettype wire

// ===== rtl/lru_keyed_entry_cache.sv =====
// A word is taken only while busy is low, never before the last word is through.
// The lookup ripples through the cell chain one cell per cycle, followed by an update step
// in which all cells change at once.
// The receiver cannot stall: each result is shown for exactly one cycle on done_o.
// Reset clears every valid bit, every recency rank and the entry count at once; the stored
// keys are not cleared and need no clearing pass.
`default_nettype none

module lru_keyed_entry_cache #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 22
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 command_i,
  input  wire logic [lkc_pkg::KEY_W-1:0]  key_i,
  input  wire logic                       fill_ok_i,
  output logic                            done_o,
  output logic                            hit_o,
  output logic                            inserted_o,
  output logic                            evicted_o,
  output logic [lkc_pkg::KEY_W-1:0]       evicted_key_o,
  output logic [lkc_pkg::SLOT_W-1:0]      slot_o,
  output logic [lkc_pkg::OCC_W-1:0]       occupancy_o
);

  lkc_pkg::scan_t      scan_w [CAPACITY+1];
  lkc_pkg::upd_t       upd;
  lkc_pkg::res_t       res;
  logic [KEY_BITS-1:0] key_bc;

  assign scan_w[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lkc_cell #(
      .Index    (i),
      .Capacity (CAPACITY),
      .KeyBits  (KEY_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_bc),
      .upd_i  (upd),
      .scan_i (scan_w[i]),
      .scan_o (scan_w[i+1])
    );
  end

  lkc_ctrl #(
    .Capacity (CAPACITY),
    .KeyBits  (KEY_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .key_i     (key_i),
    .fill_ok_i (fill_ok_i),
    .scan_i    (scan_w[CAPACITY]),
    .busy_o    (busy),
    .done_o    (done_o),
    .key_o     (key_bc),
    .upd_o     (upd),
    .res_o     (res)
  );

  assign hit_o         = res.hit;
  assign inserted_o    = res.inserted;
  assign evicted_o     = res.evicted;
  assign evicted_key_o = res.evicted_key;
  assign slot_o        = res.slot;
  assign occupancy_o   = res.occupancy;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_BITS = 22;
  localparam int unsigned KEY_W = lkc_pkg::KEY_W;
  localparam int unsigned SLOT_W = lkc_pkg::SLOT_W;
  localparam int unsigned OCC_W = lkc_pkg::OCC_W;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_TOP = {KEY_W{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic [1:0] command_i = lkc_pkg::CMD_GET;
  logic [KEY_W-1:0] key_i = '0;
  logic fill_ok_i = 1'b0;
  logic busy;
  logic done_o;
  logic hit_o;
  logic inserted_o;
  logic evicted_o;
  logic [KEY_W-1:0] evicted_key_o;
  logic [SLOT_W-1:0] slot_o;
  logic [OCC_W-1:0] occupancy_o;

  logic [KEY_W-1:0] cache_keys[CAPACITY];
  logic cache_valid[CAPACITY];
  logic [SLOT_W-1:0] cache_age[CAPACITY];
  logic [OCC_W-1:0] cache_fill;

  lkc_pkg::res_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_pct = 0;

  lru_keyed_entry_cache #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .command_i(command_i),
    .key_i(key_i),
    .fill_ok_i(fill_ok_i),
    .done_o(done_o),
    .hit_o(hit_o),
    .inserted_o(inserted_o),
    .evicted_o(evicted_o),
    .evicted_key_o(evicted_key_o),
    .slot_o(slot_o),
    .occupancy_o(occupancy_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic lkc_pkg::res_t lru_access(input logic [1:0] cmd,
                                               input logic [KEY_W-1:0] key,
                                               input logic fill_ok);
    lkc_pkg::res_t r;
    int s;
    int tgt;
    int i;
    logic [SLOT_W-1:0] age;
    r = '0;
    s = -1;
    tgt = -1;
    if (cmd == lkc_pkg::CMD_GET || cmd == lkc_pkg::CMD_REMOVE) begin
      for (i = 0; i < CAPACITY; i++) begin
        if (s < 0 && cache_valid[i] && cache_keys[i] == key) begin
          s = i;
        end
      end
    end
    case (cmd)
      lkc_pkg::CMD_GET: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          age = cache_age[s];
          for (i = 0; i < CAPACITY; i++) begin
            if (cache_valid[i] && cache_age[i] < age) begin
              cache_age[i]++;
            end
          end
          cache_age[s] = '0;
          r.slot = SLOT_W'(s);
        end else if (fill_ok) begin
          if (cache_fill >= CAPACITY) begin
            for (i = 0; i < CAPACITY; i++) begin
              if (tgt < 0 && cache_valid[i] && cache_age[i] == cache_fill - 1) begin
                tgt = i;
              end
            end
            if (tgt >= 0) begin
              r.evicted = 1'b1;
              r.evicted_key = cache_keys[tgt];
              cache_valid[tgt] = 1'b0;
              cache_fill--;
            end
          end else begin
            for (i = 0; i < CAPACITY; i++) begin
              if (tgt < 0 && !cache_valid[i]) begin
                tgt = i;
              end
            end
          end
          if (tgt >= 0) begin
            for (i = 0; i < CAPACITY; i++) begin
              if (cache_valid[i]) begin
                cache_age[i]++;
              end
            end
            cache_keys[tgt] = key;
            cache_valid[tgt] = 1'b1;
            cache_age[tgt] = '0;
            cache_fill++;
            r.inserted = 1'b1;
            r.slot = SLOT_W'(tgt);
          end
        end
      end
      lkc_pkg::CMD_REMOVE: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          age = cache_age[s];
          cache_valid[s] = 1'b0;
          cache_age[s] = '0;
          for (i = 0; i < CAPACITY; i++) begin
            if (cache_valid[i] && cache_age[i] > age) begin
              cache_age[i]--;
            end
          end
          if (cache_fill > 0) begin
            cache_fill--;
          end
        end
      end
      lkc_pkg::CMD_CLEAR: begin
        for (i = 0; i < CAPACITY; i++) begin
          cache_valid[i] = 1'b0;
          cache_age[i] = '0;
        end
        cache_fill = '0;
      end
      default: begin
      end
    endcase
    r.occupancy = cache_fill;
    return r;
  endfunction

  task automatic issue_word(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                            input logic fill_ok);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    key_i <= key;
    fill_ok_i <= fill_ok;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(lru_access(cmd, key, fill_ok));
  endtask

  task automatic test_basic_commands();
    idle_pct = 0;
    issue_word(lkc_pkg::CMD_CLEAR, '0, 1'b0);
    issue_word(lkc_pkg::CMD_GET, '0, 1'b0);
    issue_word(lkc_pkg::CMD_REMOVE, '0, 1'b1);
    issue_word(CMD_UNUSED, KEY_TOP, 1'b1);
    issue_word(lkc_pkg::CMD_GET, '0, 1'b1);
    issue_word(lkc_pkg::CMD_GET, KEY_TOP, 1'b1);
    issue_word(lkc_pkg::CMD_GET, 22'h2AAAAA, 1'b1);
    issue_word(lkc_pkg::CMD_GET, 22'h155555, 1'b0);
    issue_word(lkc_pkg::CMD_GET, '0, 1'b0);
    issue_word(lkc_pkg::CMD_GET, KEY_TOP, 1'b1);
    issue_word(lkc_pkg::CMD_REMOVE, '0, 1'b0);
    issue_word(lkc_pkg::CMD_REMOVE, '0, 1'b1);
    issue_word(lkc_pkg::CMD_GET, 22'h155555, 1'b1);
    issue_word(CMD_UNUSED, 22'h155555, 1'b0);
    issue_word(lkc_pkg::CMD_REMOVE, 22'h2AAAAA, 1'b0);
    issue_word(lkc_pkg::CMD_GET, 22'h2AAAAA, 1'b0);
    issue_word(lkc_pkg::CMD_CLEAR, KEY_TOP, 1'b1);
    issue_word(lkc_pkg::CMD_GET, 22'h155555, 1'b0);
    issue_word(lkc_pkg::CMD_REMOVE, KEY_TOP, 1'b0);
  endtask

  task automatic test_fill_and_evict();
    logic [KEY_W-1:0] filled[CAPACITY];
    int i;
    idle_pct = 61;
    issue_word(lkc_pkg::CMD_CLEAR, '0, 1'b0);
    for (i = 0; i < CAPACITY; i++) begin
      filled[i] = {i[5:0], 16'($urandom)};
      issue_word(lkc_pkg::CMD_GET, filled[i], 1'b1);
    end
    for (i = 0; i < 10; i++) begin
      issue_word(lkc_pkg::CMD_GET, filled[$urandom_range(CAPACITY - 1)], 1'($urandom));
    end
    for (i = 0; i < 12; i++) begin
      issue_word(lkc_pkg::CMD_GET, {6'($urandom), 16'($urandom)}, 1'b1);
    end
    issue_word(lkc_pkg::CMD_GET, filled[$urandom_range(CAPACITY - 1)], 1'b0);
    for (i = 0; i < 3; i++) begin
      issue_word(lkc_pkg::CMD_REMOVE, filled[$urandom_range(CAPACITY - 1)], 1'b0);
    end
    for (i = 0; i < 5; i++) begin
      issue_word(lkc_pkg::CMD_GET, KEY_TOP - KEY_W'(i), 1'b1);
    end
  endtask

  task automatic test_random_traffic(input int unsigned pct, input int unsigned count);
    logic [KEY_W-1:0] key_pool[80];
    logic [KEY_W-1:0] key;
    logic [1:0] cmd;
    int unsigned n;
    int unsigned pick;
    idle_pct = pct;
    foreach (key_pool[i]) begin
      key_pool[i] = KEY_W'($urandom);
    end
    key_pool[0] = '0;
    key_pool[1] = KEY_TOP;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 1) begin
        cmd = lkc_pkg::CMD_CLEAR;
      end else if (pick < 3) begin
        cmd = CMD_UNUSED;
      end else if (pick < 14) begin
        cmd = lkc_pkg::CMD_REMOVE;
      end else begin
        cmd = lkc_pkg::CMD_GET;
      end
      if ($urandom_range(9) == 0) begin
        key = KEY_W'($urandom);
      end else begin
        key = key_pool[$urandom_range(79)];
      end
      issue_word(cmd, key, $urandom_range(99) < 85);
    end
  endtask

  always @(posedge clk_i) begin
    lkc_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("Result word arrived with no expectation outstanding.");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit_o);
          mismatch_count++;
        end
        if (inserted_o !== want.inserted) begin
          $error("inserted: expected %0d, got %0d", want.inserted, inserted_o);
          mismatch_count++;
        end
        if (evicted_o !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, evicted_o);
          mismatch_count++;
        end
        if (evicted_key_o !== want.evicted_key) begin
          $error("evicted_key: expected %0h, got %0h", want.evicted_key, evicted_key_o);
          mismatch_count++;
        end
        if (slot_o !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot_o);
          mismatch_count++;
        end
        if (occupancy_o !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      cache_keys[i] = '0;
      cache_valid[i] = 1'b0;
      cache_age[i] = '0;
    end
    cache_fill = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_commands();
    test_fill_and_evict();
    test_random_traffic(0, 165);
    test_random_traffic(61, 165);
    test_random_traffic(19, 165);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lkc_pkg.sv
rtl/lkc_cell.sv
rtl/lkc_ctrl.sv
rtl/lru_keyed_entry_cache.sv
dv/tb_top.sv
